>>> design/mbs_pkg.sv
// Package for the Modbus PDU responder: sizes, function codes and exception codes.
// No dependencies.
`default_nettype none
package mbs_pkg;
    localparam int REG_WORDS_DEF  = 1024;
    localparam int COIL_BITS_DEF  = 2048;
    localparam int DATA_BYTES_DEF = 256;

    localparam logic [7:0] FC_RD_COILS  = 8'd1;
    localparam logic [7:0] FC_RD_INPUTS = 8'd2;
    localparam logic [7:0] FC_RD_HOLD   = 8'd3;
    localparam logic [7:0] FC_RD_INREG  = 8'd4;
    localparam logic [7:0] FC_WR_COIL   = 8'd5;
    localparam logic [7:0] FC_WR_REG    = 8'd6;
    localparam logic [7:0] FC_WR_COILS  = 8'd15;
    localparam logic [7:0] FC_WR_REGS   = 8'd16;

    localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_DATA = 8'h03;
    localparam logic [7:0] EXC_FLAG         = 8'h80;
    localparam logic [15:0] COIL_ON         = 16'hFF00;
    localparam logic [15:0] MAX_COILS_RD    = 16'd2000;
    localparam logic [15:0] MAX_REGS_RD     = 16'd125;
endpackage
`default_nettype wire

>>> design/mbs_packer.sv
// Output packer for the Modbus PDU responder: gathers response bytes into 64-bit words.
// Depends on nothing but the clock and reset; holds one finished word for the consumer.
`default_nettype none
module mbs_packer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        byte_valid,
    input  wire logic [7:0]  byte_data,
    input  wire logic        byte_last,
    output logic             byte_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_chunk,
    output logic [3:0]       m_chunk_bytes,
    output logic             m_last_chunk
);
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        ov_reg, ov_next;
    logic        ol_reg, ol_next;
    logic [63:0] od_reg, od_next;
    logic [3:0]  oc_reg, oc_next;
    logic [63:0] merged;
    logic        flush;

    assign byte_ready = !ov_reg || m_ready;
    assign merged     = acc_reg | ({56'd0, byte_data} << (6'd56 - {cnt_reg[2:0], 3'd0}));
    assign flush      = byte_valid && byte_ready && (byte_last || cnt_reg == 4'd7);

    always_comb begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        ov_next  = ov_reg;
        ol_next  = ol_reg;
        od_next  = od_reg;
        oc_next  = oc_reg;
        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end
        if (byte_valid && byte_ready) begin
            if (flush) begin
                od_next  = merged;
                oc_next  = cnt_reg + 4'd1;
                ol_next  = byte_last;
                ov_next  = 1'b1;
                acc_next = 64'd0;
                cnt_next = 4'd0;
            end else begin
                acc_next = merged;
                cnt_next = cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 64'd0;
            cnt_reg <= 4'd0;
            ov_reg  <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
        ol_reg <= ol_next;
        od_reg <= od_next;
        oc_reg <= oc_next;
    end

    assign m_valid       = ov_reg;
    assign m_chunk       = od_reg;
    assign m_chunk_bytes = oc_reg;
    assign m_last_chunk  = ol_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && !m_ready |=> ov_reg && $stable(od_reg) && $stable(oc_reg) && $stable(ol_reg))
        else $error("packer dropped or changed a held word");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 4'd7)
        else $error("packer fill count out of range");
    a_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg |-> (oc_reg != 4'd0 && oc_reg <= 4'd8))
        else $error("packer word byte count out of range");
endmodule
`default_nettype wire

>>> design/modbus_slave_pdu_responder.sv
// Top level of the Modbus slave PDU responder: request buffer, tables, sequencer.
// Depends on mbs_pkg and mbs_packer.
`default_nettype none
// A request arrives as a run of input words; each may carry one data byte, which is
// buffered, and the word with s_request_last set triggers the response. A word
// without request_last leaves the block idle and ready for the next word. On the
// last word a sequencer walks the request one step per cycle, unless the output
// packer holds it off, through one shared address adder and compare, reading or
// writing one register, one coil or one buffered byte per step, and hands at most
// one response byte per cycle to the output packer; the response leaves as 64-bit
// words with the first byte in bits 63..56. A register read takes a read step, a
// high byte step and a low byte step per register; a coil read an address step and
// a read step per coil; a multiple coil write a fetch step and a write step per
// coil; a multiple register write two buffer reads and a write per register. After
// reset the sequencer first clears both tables, one register and one coil per
// cycle, up to the larger of REG_WORDS and COIL_BITS, and accepts no word then.
// The slave address register may be written at any time the block is idle.
module modbus_slave_pdu_responder #(
    parameter int REG_WORDS  = mbs_pkg::REG_WORDS_DEF,
    parameter int COIL_BITS  = mbs_pkg::COIL_BITS_DEF,
    parameter int DATA_BYTES = mbs_pkg::DATA_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_operation,
    input  wire logic [15:0] s_start_address,
    input  wire logic [15:0] s_quantity,
    input  wire logic        s_data_present,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_request_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_chunk,
    output logic [3:0]       m_chunk_bytes,
    output logic             m_last_chunk
);
    localparam int RW = (REG_WORDS  > 1) ? $clog2(REG_WORDS)  : 1;
    localparam int CW = $clog2(COIL_BITS);
    localparam int DW = $clog2(DATA_BYTES);
    localparam int BW = DW + 1;
    localparam int CLR_N = (REG_WORDS > COIL_BITS) ? REG_WORDS : COIL_BITS;
    localparam int KW = $clog2(CLR_N) + 1;

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_HEAD  = 10'b0000000100,
        ST_RDC   = 10'b0000001000,
        ST_RDR   = 10'b0000010000,
        ST_WRC   = 10'b0000100000,
        ST_WRR   = 10'b0001000000,
        ST_ECHO  = 10'b0010000000,
        ST_FETCH = 10'b0100000000,
        ST_DRAIN = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [7:0]  slave_reg;
    logic [BW-1:0] bcnt_reg, bcnt_next;
    logic [7:0]  op_reg;
    logic [15:0] start_reg, qty_reg;
    logic [16:0] idx_reg, idx_next;
    logic [3:0]  hp_reg, hp_next;
    logic [7:0]  hb_reg, hb_next;
    logic [7:0]  rd_hold_reg;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  acc_reg, acc_next;
    logic        exc_reg, exc_next;
    logic [7:0]  ecode_reg, ecode_next;
    logic [KW-1:0] clr_reg;
    logic        phase_reg, phase_next;

    logic [15:0] reg_mem [REG_WORDS];
    logic        coil_mem [COIL_BITS];
    logic [7:0]  buf_mem [DATA_BYTES];
    logic [15:0] reg_q;
    logic        coil_q;
    logic [7:0]  buf_q;

    // Shared address unit: start plus index and a range check.
    logic [16:0] abs_addr;
    logic        reg_in, coil_in;
    assign abs_addr = {1'b0, start_reg} + idx_reg;
    assign reg_in   = abs_addr < 17'(REG_WORDS);
    assign coil_in  = abs_addr < 17'(COIL_BITS);

    logic        pb_valid, pb_last, pb_ready;
    logic [7:0]  pb_data;

    logic        rd_en_r, rd_en_c, wr_en_r, wr_en_c;
    logic [15:0] wr_val_r;
    logic        wr_val_c;
    logic [DW-1:0] buf_addr;
    logic        acc_s;
    logic [15:0] nbytes_c;
    logic [16:0] qty2;
    logic [BW-1:0] coils_limit_b;
    logic [16:0] wr_coils_n;

    assign s_ready = (state_reg == ST_IDLE);
    assign acc_s   = s_valid && s_ready;
    assign qty2    = {qty_reg, 1'b0};
    assign nbytes_c = (qty_reg + 16'd7) >> 3;
    assign coils_limit_b = bcnt_reg - BW'(1);
    assign wr_coils_n = ({1'b0, qty_reg} < 17'({coils_limit_b, 3'd0})) ?
                        {1'b0, qty_reg} : 17'({coils_limit_b, 3'd0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_reg <= 8'd1;
        end else if (cfg_wr_en) begin
            slave_reg <= cfg_wr_data;
        end
    end

    // Buffer write on accepted data; reads at buf_addr, registered.
    always_ff @(posedge aclk) begin
        if (acc_s && s_data_present && bcnt_reg < BW'(DATA_BYTES)) begin
            buf_mem[bcnt_reg[DW-1:0]] <= s_data_byte;
        end
        buf_q <= buf_mem[buf_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en_r) begin
            reg_mem[state_reg == ST_CLEAR ? clr_reg[RW-1:0] : abs_addr[RW-1:0]] <= wr_val_r;
        end
        if (rd_en_r) begin
            reg_q <= reg_mem[abs_addr[RW-1:0]];
        end
    end
    always_ff @(posedge aclk) begin
        if (wr_en_c) begin
            coil_mem[state_reg == ST_CLEAR ? clr_reg[CW-1:0] : abs_addr[CW-1:0]] <= wr_val_c;
        end
        if (rd_en_c) begin
            coil_q <= coil_mem[abs_addr[CW-1:0]];
        end
    end

    // phase_reg is set once a read or fetch has been addressed and marks the step that uses its data.
    always_comb begin
        state_next = state_reg;
        bcnt_next  = bcnt_reg;
        idx_next   = idx_reg;
        hp_next    = hp_reg;
        hb_next    = hb_reg;
        bit_next   = bit_reg;
        acc_next   = acc_reg;
        exc_next   = exc_reg;
        ecode_next = ecode_reg;
        phase_next = phase_reg;
        pb_valid = 1'b0;
        pb_data  = 8'd0;
        pb_last  = 1'b0;
        rd_en_r = 1'b0;
        rd_en_c = 1'b0;
        wr_en_r = 1'b0;
        wr_en_c = 1'b0;
        wr_val_r = 16'd0;
        wr_val_c = 1'b0;
        buf_addr = idx_reg[DW-1:0];
        case (state_reg)
            ST_CLEAR: begin
                wr_en_r = clr_reg < KW'(REG_WORDS);
                wr_en_c = clr_reg < KW'(COIL_BITS);
                if (clr_reg == KW'(CLR_N - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc_s) begin
                    if (s_data_present && bcnt_reg < BW'(DATA_BYTES)) begin
                        bcnt_next = bcnt_reg + BW'(1);
                    end
                    if (s_request_last) begin
                        state_next = ST_FETCH;
                        idx_next   = 17'd0;
                        phase_next = 1'b0;
                        hp_next    = 4'd0;
                    end
                end
            end
            ST_FETCH: begin
                // Steps 0 and 1 address buffer bytes 0 and 1; step 2 sees byte 0 in
                // hb and byte 1 on the read port and decides the reply.
                case (hp_reg)
                    4'd0: begin
                        buf_addr = DW'(0);
                        hp_next  = 4'd1;
                    end
                    4'd1: begin
                        buf_addr = DW'(1);
                        hb_next  = buf_q;
                        hp_next  = 4'd2;
                    end
                    default: begin
                        phase_next = 1'b0;
                        hp_next    = 4'd0;
                        exc_next   = 1'b0;
                        state_next = ST_HEAD;
                        case (op_reg)
                            mbs_pkg::FC_RD_COILS, mbs_pkg::FC_RD_INPUTS: begin
                                if (qty_reg == 16'd0 || qty_reg > mbs_pkg::MAX_COILS_RD) begin
                                    exc_next = 1'b1;
                                    ecode_next = mbs_pkg::EXC_ILLEGAL_DATA;
                                end
                            end
                            mbs_pkg::FC_RD_HOLD, mbs_pkg::FC_RD_INREG: begin
                                if (qty_reg == 16'd0 || qty_reg > mbs_pkg::MAX_REGS_RD) begin
                                    exc_next = 1'b1;
                                    ecode_next = mbs_pkg::EXC_ILLEGAL_DATA;
                                end
                            end
                            mbs_pkg::FC_WR_COIL, mbs_pkg::FC_WR_REG: begin
                                if (bcnt_reg >= BW'(2)) begin
                                    if (op_reg == mbs_pkg::FC_WR_COIL) begin
                                        wr_en_c  = coil_in;
                                        wr_val_c = {hb_reg, buf_q} == mbs_pkg::COIL_ON;
                                    end else begin
                                        wr_en_r  = reg_in;
                                        wr_val_r = {hb_reg, buf_q};
                                    end
                                end
                            end
                            mbs_pkg::FC_WR_COILS: begin
                                if (bcnt_reg == BW'(0)) begin
                                    exc_next = 1'b1;
                                    ecode_next = mbs_pkg::EXC_ILLEGAL_DATA;
                                end else begin
                                    state_next = ST_WRC;
                                end
                            end
                            mbs_pkg::FC_WR_REGS: begin
                                if (bcnt_reg == BW'(0) || {9'd0, hb_reg} != qty2 ||
                                        {{(17-BW){1'b0}}, bcnt_reg} <
                                        {9'd0, hb_reg} + 17'd1) begin
                                    exc_next = 1'b1;
                                    ecode_next = mbs_pkg::EXC_ILLEGAL_DATA;
                                end else begin
                                    state_next = ST_WRR;
                                    idx_next   = 17'd0;
                                end
                            end
                            default: begin
                                exc_next = 1'b1;
                                ecode_next = mbs_pkg::EXC_ILLEGAL_FUNC;
                            end
                        endcase
                    end
                endcase
            end
            ST_WRC: begin
                // Per coil a wait step for buffer byte 1+idx/8, then the coil write.
                buf_addr = DW'(17'd1 + (idx_reg >> 3));
                if (idx_reg >= wr_coils_n) begin
                    state_next = ST_HEAD;
                    idx_next   = 17'd0;
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    wr_en_c  = coil_in;
                    wr_val_c = buf_q[idx_reg[2:0]];
                    idx_next = idx_reg + 17'd1;
                    phase_next = 1'b0;
                end
            end
            ST_WRR: begin
                // Two buffer reads then a register write per value.
                buf_addr = DW'(17'd1 + {idx_reg[15:0], 1'b0} + {16'd0, phase_reg});
                if (idx_reg >= {1'b0, qty_reg}) begin
                    state_next = ST_HEAD;
                    idx_next   = 17'd0;
                end else begin
                    if (bit_reg == 3'd0) begin
                        bit_next = 3'd1;
                        phase_next = 1'b1;
                    end else if (bit_reg == 3'd1) begin
                        acc_next = buf_q;
                        bit_next = 3'd2;
                        phase_next = 1'b0;
                    end else begin
                        wr_en_r  = reg_in;
                        wr_val_r = {acc_reg, buf_q};
                        bit_next = 3'd0;
                        idx_next = idx_reg + 17'd1;
                    end
                end
            end
            ST_HEAD: begin
                // Header bytes, and the exception code on an exception; hp counts bytes already sent.
                pb_valid = 1'b1;
                case (hp_reg)
                    4'd0: pb_data = slave_reg;
                    4'd1: pb_data = exc_reg ? (op_reg | mbs_pkg::EXC_FLAG) : op_reg;
                    default: pb_data = exc_reg ? ecode_reg : 8'd0;
                endcase
                if (!exc_reg && hp_reg >= 4'd2) begin
                    pb_valid = 1'b0;
                    state_next = ST_ECHO;
                end
                if (exc_reg && hp_reg == 4'd2) begin
                    pb_last = 1'b1;
                end
                if (pb_valid && pb_ready) begin
                    hp_next = hp_reg + 4'd1;
                    if (pb_last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_ECHO: begin
                pb_valid = 1'b1;
                case (op_reg)
                    mbs_pkg::FC_RD_COILS, mbs_pkg::FC_RD_INPUTS: begin
                        pb_data = nbytes_c[7:0];
                        if (pb_ready) begin
                            state_next = ST_RDC;
                            idx_next = 17'd0;
                            bit_next = 3'd0;
                            acc_next = 8'd0;
                            phase_next = 1'b0;
                        end
                    end
                    mbs_pkg::FC_RD_HOLD, mbs_pkg::FC_RD_INREG: begin
                        pb_data = qty2[7:0];
                        if (pb_ready) begin
                            state_next = ST_RDR;
                            idx_next = 17'd0;
                            phase_next = 1'b0;
                            hp_next = 4'd0;
                        end
                    end
                    default: begin
                        // Echo: addr hi, addr lo, then data or quantity.
                        case (hp_reg)
                            4'd2: pb_data = start_reg[15:8];
                            4'd3: pb_data = start_reg[7:0];
                            4'd4: pb_data = (op_reg == mbs_pkg::FC_WR_COIL ||
                                             op_reg == mbs_pkg::FC_WR_REG) ?
                                            hb_reg : qty_reg[15:8];
                            default: pb_data = (op_reg == mbs_pkg::FC_WR_COIL ||
                                                op_reg == mbs_pkg::FC_WR_REG) ?
                                               rd_hold_reg : qty_reg[7:0];
                        endcase
                        if (op_reg == mbs_pkg::FC_WR_COIL || op_reg == mbs_pkg::FC_WR_REG) begin
                            pb_last = (hp_reg == 4'd3 && bcnt_reg == BW'(0)) ||
                                      (hp_reg == 4'd4 && bcnt_reg == BW'(1)) ||
                                      (hp_reg == 4'd5);
                        end else begin
                            pb_last = hp_reg == 4'd5;
                        end
                        if (pb_ready) begin
                            hp_next = hp_reg + 4'd1;
                            if (pb_last) begin
                                state_next = ST_DRAIN;
                            end
                        end
                    end
                endcase
            end
            ST_RDC: begin
                // Per coil: address, then registered read.
                if (!phase_reg) begin
                    rd_en_c = 1'b1;
                    phase_next = 1'b1;
                end else begin
                    if (idx_reg < {1'b0, qty_reg} && coil_in && coil_q) begin
                        acc_next = acc_reg | (8'd1 << bit_reg);
                    end
                    if (bit_reg == 3'd7) begin
                        pb_valid = 1'b1;
                        pb_data  = acc_next;
                        pb_last  = (idx_reg + 17'd1) >= {1'b0, qty_reg};
                        if (pb_ready) begin
                            acc_next = 8'd0;
                            bit_next = 3'd0;
                            idx_next = idx_reg + 17'd1;
                            phase_next = 1'b0;
                            if (pb_last) begin
                                state_next = ST_DRAIN;
                            end
                        end else begin
                            acc_next = acc_reg;
                        end
                    end else begin
                        bit_next = bit_reg + 3'd1;
                        idx_next = idx_reg + 17'd1;
                        phase_next = 1'b0;
                    end
                end
            end
            ST_RDR: begin
                // Register read, then high byte, then low byte.
                if (hp_reg == 4'd0) begin
                    rd_en_r = 1'b1;
                    hp_next = 4'd1;
                end else begin
                    pb_valid = 1'b1;
                    if (hp_reg == 4'd1) begin
                        pb_data = reg_in ? reg_q[15:8] : 8'd0;
                        if (pb_ready) begin
                            hp_next = 4'd2;
                        end
                    end else begin
                        pb_data = reg_in ? reg_q[7:0] : 8'd0;
                        pb_last = (idx_reg + 17'd1) == {1'b0, qty_reg};
                        if (pb_ready) begin
                            hp_next = 4'd0;
                            idx_next = idx_reg + 17'd1;
                            if (pb_last) begin
                                state_next = ST_DRAIN;
                            end
                        end
                    end
                end
            end
            ST_DRAIN: begin
                bcnt_next  = BW'(0);
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            bcnt_reg  <= '0;
            clr_reg   <= '0;
            phase_reg <= 1'b0;
            hp_reg    <= 4'd0;
            bit_reg   <= 3'd0;
            exc_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            bcnt_reg  <= bcnt_next;
            phase_reg <= phase_next;
            hp_reg    <= hp_next;
            bit_reg   <= bit_next;
            exc_reg   <= exc_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + KW'(1);
            end
        end
        idx_reg   <= idx_next;
        hb_reg    <= hb_next;
        acc_reg   <= acc_next;
        ecode_reg <= ecode_next;
        if (state_reg == ST_FETCH && hp_reg == 4'd2) begin
            rd_hold_reg <= buf_q;
        end
        if (acc_s && s_request_last) begin
            op_reg    <= s_operation;
            start_reg <= s_start_address;
            qty_reg   <= s_quantity;
        end
    end

    mbs_packer u_packer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_valid    (pb_valid),
        .byte_data     (pb_data),
        .byte_last     (pb_last),
        .byte_ready    (pb_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chunk       (m_chunk),
        .m_chunk_bytes (m_chunk_bytes),
        .m_last_chunk  (m_last_chunk)
    );

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("sequencer state not one-hot");
    a_bcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        bcnt_reg <= BW'(DATA_BYTES))
        else $error("buffer count overflow");
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAIN |=> bcnt_reg == BW'(0))
        else $error("buffer count not cleared after response");
endmodule
`default_nettype wire

>>> tb/modbus_slave_pdu_responder_test.sv
// Self-checking testbench for the Modbus slave PDU responder.
// Depends on mbs_pkg and the design files of modbus_slave_pdu_responder.
`default_nettype none
module modbus_slave_pdu_responder_test;
    localparam int REG_N  = mbs_pkg::REG_WORDS_DEF;
    localparam int COIL_N = mbs_pkg::COIL_BITS_DEF;
    localparam int BUF_N  = mbs_pkg::DATA_BYTES_DEF;
    localparam int CYCLE_LIMIT = 5000000;
    // A function code that the block does not implement.
    localparam logic [7:0] FC_UNKNOWN = 8'd7;

    typedef struct packed {
        logic [7:0]  op;
        logic [15:0] addr;
        logic [15:0] qty;
        logic        has_data;
        logic [7:0]  data;
        logic        last;
    } req_word_t;

    typedef struct packed {
        logic [63:0] chunk;
        logic [3:0]  nbytes;
        logic        last;
    } resp_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_operation = 8'd0;
    logic [15:0] s_start_address = 16'd0;
    logic [15:0] s_quantity = 16'd0;
    logic s_data_present = 1'b0;
    logic [7:0] s_data_byte = 8'd0;
    logic s_request_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [63:0] m_chunk;
    logic [3:0] m_chunk_bytes;
    logic m_last_chunk;

    modbus_slave_pdu_responder u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_start_address(s_start_address),
        .s_quantity(s_quantity), .s_data_present(s_data_present),
        .s_data_byte(s_data_byte), .s_request_last(s_request_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_chunk(m_chunk), .m_chunk_bytes(m_chunk_bytes), .m_last_chunk(m_last_chunk)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mirror of the slave's tables, its request buffer and its station address.
    logic [15:0] reg_mirror [0:REG_N-1];
    bit          coil_mirror [0:COIL_N-1];
    logic [7:0]  pending_bytes [0:BUF_N-1];
    int unsigned pending_count;
    logic [7:0]  station_addr;

    req_word_t  word_q[$];
    resp_word_t chunk_q[$];
    int unsigned words_sent;
    int unsigned requests_done;
    int unsigned chunks_seen;
    int unsigned mismatches;
    int unsigned cycles;
    bit s_taken, m_taken;
    int unsigned s_gap, m_gap;
    // While calm is set neither side idles, so back-to-back transfers are exercised.
    bit calm;

    function automatic logic [15:0] reg_at(int unsigned a);
        return (a < REG_N) ? reg_mirror[a] : 16'd0;
    endfunction

    function automatic bit coil_at(int unsigned a);
        return (a < COIL_N) ? coil_mirror[a] : 1'b0;
    endfunction

    // Apply one accepted request word to the mirror and queue the response chunks.
    task automatic predict_response(input req_word_t w);
        logic [7:0] rsp[$];
        int unsigned qty, start, n, bc;
        logic [7:0] b;
        logic [15:0] v;
        resp_word_t c;
        if (w.has_data && pending_count < BUF_N) begin
            pending_bytes[pending_count] = w.data;
            pending_count++;
        end
        if (!w.last) return;
        qty = w.qty;
        start = w.addr;
        case (w.op)
            mbs_pkg::FC_RD_COILS, mbs_pkg::FC_RD_INPUTS: begin
                if (qty < 1 || qty > mbs_pkg::MAX_COILS_RD) begin
                    rsp = '{station_addr, w.op | mbs_pkg::EXC_FLAG,
                            mbs_pkg::EXC_ILLEGAL_DATA};
                end else begin
                    n = (qty + 7) / 8;
                    rsp = '{station_addr, w.op, n[7:0]};
                    for (int i = 0; i < n; i++) begin
                        b = 8'd0;
                        for (int k = 0; k < 8; k++)
                            if (i * 8 + k < qty && coil_at(start + i * 8 + k)) b[k] = 1'b1;
                        rsp.push_back(b);
                    end
                end
            end
            mbs_pkg::FC_RD_HOLD, mbs_pkg::FC_RD_INREG: begin
                if (qty < 1 || qty > mbs_pkg::MAX_REGS_RD) begin
                    rsp = '{station_addr, w.op | mbs_pkg::EXC_FLAG,
                            mbs_pkg::EXC_ILLEGAL_DATA};
                end else begin
                    n = qty * 2;
                    rsp = '{station_addr, w.op, n[7:0]};
                    for (int i = 0; i < qty; i++) begin
                        v = reg_at(start + i);
                        rsp.push_back(v[15:8]);
                        rsp.push_back(v[7:0]);
                    end
                end
            end
            mbs_pkg::FC_WR_COIL, mbs_pkg::FC_WR_REG: begin
                if (pending_count >= 2) begin
                    v = {pending_bytes[0], pending_bytes[1]};
                    if (w.op == mbs_pkg::FC_WR_COIL) begin
                        if (start < COIL_N) coil_mirror[start] = (v == mbs_pkg::COIL_ON);
                    end else if (start < REG_N) begin
                        reg_mirror[start] = v;
                    end
                end
                rsp = '{station_addr, w.op, w.addr[15:8], w.addr[7:0]};
                for (int i = 0; i < pending_count && i < 2; i++) rsp.push_back(pending_bytes[i]);
            end
            mbs_pkg::FC_WR_COILS: begin
                if (pending_count < 1) begin
                    rsp = '{station_addr, w.op | mbs_pkg::EXC_FLAG,
                            mbs_pkg::EXC_ILLEGAL_DATA};
                end else begin
                    // Only coils covered by bytes that actually arrived are written.
                    n = (pending_count - 1) * 8;
                    if (qty < n) n = qty;
                    for (int i = 0; i < n; i++)
                        if (start + i < COIL_N)
                            coil_mirror[start + i] = pending_bytes[1 + i / 8][i % 8];
                    rsp = '{station_addr, w.op, w.addr[15:8], w.addr[7:0],
                            w.qty[15:8], w.qty[7:0]};
                end
            end
            mbs_pkg::FC_WR_REGS: begin
                bc = (pending_count >= 1) ? pending_bytes[0] : 0;
                if (pending_count < 1 || bc != qty * 2 || pending_count < 1 + bc) begin
                    rsp = '{station_addr, w.op | mbs_pkg::EXC_FLAG,
                            mbs_pkg::EXC_ILLEGAL_DATA};
                end else begin
                    for (int i = 0; i < qty; i++)
                        if (start + i < REG_N)
                            reg_mirror[start + i] = {pending_bytes[1 + 2 * i],
                                                     pending_bytes[2 + 2 * i]};
                    rsp = '{station_addr, w.op, w.addr[15:8], w.addr[7:0],
                            w.qty[15:8], w.qty[7:0]};
                end
            end
            default: rsp = '{station_addr, w.op | mbs_pkg::EXC_FLAG,
                             mbs_pkg::EXC_ILLEGAL_FUNC};
        endcase
        pending_count = 0;
        requests_done++;
        // Pack the response eight bytes to a word, first byte on top.
        while (rsp.size() > 0) begin
            c = '0;
            for (int j = 0; j < 8 && rsp.size() > 0; j++) begin
                c.chunk[63 - 8 * j -: 8] = rsp.pop_front();
                c.nbytes++;
            end
            c.last = (rsp.size() == 0);
            chunk_q.push_back(c);
        end
    endtask

    // Input monitor and output checker, both sampled at the rising edge.
    always @(posedge aclk) begin
        resp_word_t want;
        cycles++;
        if (s_valid && s_ready) begin
            s_taken = 1'b1;
            predict_response({s_operation, s_start_address, s_quantity,
                              s_data_present, s_data_byte, s_request_last});
        end
        if (m_valid && m_ready) begin
            m_taken = 1'b1;
            chunks_seen++;
            if (chunk_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response word %h bytes %0d last %0b",
                             m_chunk, m_chunk_bytes, m_last_chunk);
            end else begin
                want = chunk_q.pop_front();
                if (m_chunk !== want.chunk || m_chunk_bytes !== want.nbytes ||
                    m_last_chunk !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: word %h/%0d/%0b, expected %h/%0d/%0b",
                                 m_chunk, m_chunk_bytes, m_last_chunk,
                                 want.chunk, want.nbytes, want.last);
                end
            end
        end
    end

    // Request driver: words come from word_q with a random gap before each one.
    always @(negedge aclk) begin
        logic nv;
        req_word_t w;
        nv = s_valid;
        if (s_valid && s_taken) begin
            nv = 1'b0;
            s_gap = calm ? 0 : $urandom_range(0, 9);
        end
        s_taken = 1'b0;
        if (aresetn && !nv) begin
            if (s_gap > 0) begin
                s_gap--;
            end else if (word_q.size() > 0) begin
                w = word_q.pop_front();
                nv = 1'b1;
                s_operation <= w.op;
                s_start_address <= w.addr;
                s_quantity <= w.qty;
                s_data_present <= w.has_data;
                s_data_byte <= w.data;
                s_request_last <= w.last;
            end
        end
        s_valid <= nv;
    end

    // Response receiver: a random stall before each word is taken.
    always @(negedge aclk) begin
        if (m_taken) m_gap = calm ? 0 : $urandom_range(0, 9);
        m_taken = 1'b0;
        if (m_gap > 0) begin
            m_ready <= 1'b0;
            m_gap--;
        end else begin
            m_ready <= aresetn;
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("modbus_slave_pdu_responder test failed");
            $finish;
        end
    end

    // Queue one request: one word per data byte, with some empty words between.
    task automatic send_request(input logic [7:0] op, input logic [15:0] addr,
                                input logic [15:0] qty, input logic [7:0] bytes[$],
                                input bit last_carries_data);
        req_word_t w;
        while (bytes.size() > 0) begin
            if ($urandom_range(0, 7) == 0) begin
                w = {8'($urandom), 16'($urandom), 16'($urandom), 1'b0, 8'($urandom), 1'b0};
                word_q.push_back(w);
                words_sent++;
            end
            w = {8'($urandom), 16'($urandom), 16'($urandom), 1'b1, bytes.pop_front(), 1'b0};
            if (bytes.size() == 0 && last_carries_data) begin
                w.op = op;
                w.addr = addr;
                w.qty = qty;
                w.last = 1'b1;
            end
            word_q.push_back(w);
            words_sent++;
            if (w.last) return;
        end
        word_q.push_back({op, addr, qty, 1'b0, 8'($urandom), 1'b1});
        words_sent++;
    endtask

    function automatic logic [15:0] pick_addr(int unsigned depth);
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'(depth - $urandom_range(1, 8));
            default: return 16'($urandom_range(0, 63));
        endcase
    endfunction

    // One random request, mostly well formed.
    task automatic random_request();
        logic [7:0] d[$];
        logic [7:0] op;
        logic [15:0] qty;
        int unsigned sel;
        sel = $urandom_range(0, 19);
        d = {};
        case (sel)
            0, 1, 2: begin
                op = sel[0] ? mbs_pkg::FC_RD_COILS : mbs_pkg::FC_RD_INPUTS;
                qty = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 2002))
                                                   : 16'($urandom_range(1, 40));
                send_request(op, pick_addr(COIL_N), qty, d, 1'b0);
            end
            3, 4, 5: begin
                op = sel[0] ? mbs_pkg::FC_RD_HOLD : mbs_pkg::FC_RD_INREG;
                qty = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 130))
                                                   : 16'($urandom_range(1, 12));
                send_request(op, pick_addr(REG_N), qty, d, 1'b0);
            end
            6, 7, 8: begin
                op = (sel == 6) ? mbs_pkg::FC_WR_COIL : mbs_pkg::FC_WR_REG;
                if (op == mbs_pkg::FC_WR_COIL && $urandom_range(0, 1)) d = '{8'hFF, 8'h00};
                else d = '{8'($urandom), 8'($urandom)};
                if ($urandom_range(0, 9) == 0) void'(d.pop_back());
                send_request(op, pick_addr(op == mbs_pkg::FC_WR_COIL ? COIL_N : REG_N),
                             16'($urandom), d, $urandom_range(0, 1));
            end
            9, 10, 11: begin
                qty = 16'($urandom_range(1, 40));
                d.push_back(8'((qty + 7) / 8));
                for (int i = 0; i < (qty + 7) / 8; i++) d.push_back(8'($urandom));
                if ($urandom_range(0, 5) == 0) void'(d.pop_back());
                send_request(mbs_pkg::FC_WR_COILS, pick_addr(COIL_N), qty, d,
                             $urandom_range(0, 1));
            end
            12, 13, 14, 15: begin
                qty = 16'($urandom_range(0, 10));
                d.push_back(8'(qty * 2));
                for (int i = 0; i < qty * 2; i++) d.push_back(8'($urandom));
                case ($urandom_range(0, 7))
                    0: d[0] = d[0] + 8'd2;
                    1: if (d.size() > 1) void'(d.pop_back());
                    default: ;
                endcase
                send_request(mbs_pkg::FC_WR_REGS, pick_addr(REG_N), qty, d,
                             $urandom_range(0, 1));
            end
            default: begin
                // Mostly codes the block knows, sometimes anything at all.
                op = ($urandom_range(0, 3) == 0) ? 8'($urandom) : mbs_pkg::FC_RD_HOLD;
                send_request(op, pick_addr(REG_N), 16'($urandom_range(1, 4)), d, 1'b0);
            end
        endcase
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (word_q.size() > 0 || s_valid || chunk_q.size() > 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_station(input logic [7:0] a);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= a;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        station_addr = a;
    endtask

    initial begin
        logic [7:0] d[$];
        logic [7:0] stations[3];
        for (int i = 0; i < REG_N; i++) reg_mirror[i] = '0;
        for (int i = 0; i < COIL_N; i++) coil_mirror[i] = 1'b0;
        pending_count = 0;
        station_addr = 8'd1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests first, at the reset station address.
        d = {};
        send_request(mbs_pkg::FC_RD_HOLD, 16'd0, 16'd0, d, 1'b0);
        d = '{8'hAB, 8'hCD};
        send_request(mbs_pkg::FC_WR_REG, 16'd5, 16'd0, d, 1'b1);
        d = {};
        send_request(mbs_pkg::FC_RD_HOLD, 16'd3, 16'd5, d, 1'b0);
        d = '{8'hFF, 8'h00};
        send_request(mbs_pkg::FC_WR_COIL, 16'd10, 16'd0, d, 1'b1);
        d = '{8'h12, 8'h34};
        send_request(mbs_pkg::FC_WR_COIL, 16'd11, 16'd0, d, 1'b0);
        d = '{8'hFF};
        send_request(mbs_pkg::FC_WR_COIL, 16'd12, 16'd0, d, 1'b1);
        d = {};
        send_request(mbs_pkg::FC_WR_REG, 16'd6, 16'd0, d, 1'b0);
        send_request(mbs_pkg::FC_RD_COILS, 16'd0, mbs_pkg::MAX_COILS_RD, d, 1'b0);
        send_request(mbs_pkg::FC_RD_INPUTS, 16'd0, mbs_pkg::MAX_COILS_RD + 16'd1, d, 1'b0);
        send_request(mbs_pkg::FC_RD_INREG, 16'hFFE0, mbs_pkg::MAX_REGS_RD, d, 1'b0);
        send_request(mbs_pkg::FC_RD_INREG, 16'd0, mbs_pkg::MAX_REGS_RD + 16'd1, d, 1'b0);
        send_request(mbs_pkg::FC_RD_HOLD, 16'hFFFF, 16'hFFFF, d, 1'b0);
        send_request(mbs_pkg::FC_WR_COILS, 16'd20, 16'd10, d, 1'b0);
        d = '{8'd2, 8'hA5, 8'h03};
        send_request(mbs_pkg::FC_WR_COILS, 16'd20, 16'd10, d, 1'b1);
        d = '{8'd4, 8'h11, 8'h22, 8'h33, 8'h44};
        send_request(mbs_pkg::FC_WR_REGS, 16'd1022, 16'd2, d, 1'b1);
        d = '{8'd6, 8'h11, 8'h22, 8'h33, 8'h44};
        send_request(mbs_pkg::FC_WR_REGS, 16'd0, 16'd2, d, 1'b1);
        d = '{8'd4, 8'h11, 8'h22, 8'h33};
        send_request(mbs_pkg::FC_WR_REGS, 16'd0, 16'd2, d, 1'b1);
        d = {};
        send_request(mbs_pkg::FC_WR_REGS, 16'd0, 16'd2, d, 1'b0);
        d = '{8'h55, 8'hAA};
        send_request(mbs_pkg::FC_WR_REG, 16'hFFFF, 16'd0, d, 1'b1);
        d = {};
        send_request(8'd0, 16'd0, 16'd0, d, 1'b0);
        send_request(8'hFF, 16'hFFFF, 16'hFFFF, d, 1'b0);
        send_request(FC_UNKNOWN, 16'd1, 16'd1, d, 1'b0);
        send_request(mbs_pkg::FC_RD_HOLD, 16'd1020, 16'd6, d, 1'b0);
        send_request(mbs_pkg::FC_RD_COILS, 16'd16, 16'd64, d, 1'b0);
        drain();

        // Random requests under several station addresses, extremes included.
        stations = '{8'h00, 8'hFF, 8'($urandom)};
        for (int p = 0; p < 4; p++) begin
            if (p > 0) set_station(stations[p - 1]);
            calm = (p == 2);
            for (int start_words = words_sent; words_sent < start_words + 25; )
                random_request();
            drain();
        end
        repeat (50) @(posedge aclk);

        $display("%0d request words, %0d requests, %0d response words checked",
                 words_sent, requests_done, chunks_seen);
        if (mismatches == 0 && chunk_q.size() == 0) begin
            $display("modbus_slave_pdu_responder test passed");
        end else begin
            $display("%0d mismatches, %0d words still expected", mismatches, chunk_q.size());
            $display("modbus_slave_pdu_responder test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
